// ===== rtl/lru_cache_with_expiry_assert.svh =====
// ----------------------------------------------------------------------------
// LRU cache with expiry - assertion macros
// Clocked concurrent assertions, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_WITH_EXPIRY_ASSERT_SVH
`define LRU_CACHE_WITH_EXPIRY_ASSERT_SVH

`ifndef ASSERT_OFF
// check prop on every clock edge outside reset
`define LCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check prop on every clock edge, reset included
`define LCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/lce_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU cache with expiry - package
// Opcodes, register indexes, fixed field widths and slot control structs.
// ----------------------------------------------------------------------------
package lce_pkg;

    localparam int OPCODE_W   = 2;
    localparam int KEY_IN_W   = 32;
    localparam int CAP_W      = 5;
    localparam int EXPIRY_W   = 16;
    localparam int OCC_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CAP_W-1:0]    CAPACITY_RESET = 5'd16;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET   = 16'd60;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_EXPIRY   = 1'b1
    } t_cfg_idx;

    // broadcast action for all slots in one cycle
    typedef struct packed {
        logic touch;    // hit slot becomes most recent
        logic restamp;  // hit slot takes the current time
        logic drop;     // hit slot is removed
        logic fill;     // new key goes in, victim may go out
    } t_slot_cmd;

    typedef struct packed {
        logic valid;
        logic match;    // valid and key equal
        logic lru;      // valid and least recent
    } t_slot_stat;

endpackage

// ===== rtl/lce_slot.sv =====
// ----------------------------------------------------------------------------
// LRU cache with expiry - one slot
// Key, time stamp and recency rank of one entry, with its key compare.
// ----------------------------------------------------------------------------
module lce_slot #(
    parameter int KEY_BITS  = 32,
    parameter int TIME_BITS = 32,
    parameter int RANK_W    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lce_pkg::t_slot_cmd     i_cmd,
    input  logic                   i_hit,
    input  logic                   i_victim,
    input  logic                   i_new,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [TIME_BITS-1:0]   i_time,
    input  logic [RANK_W-1:0]      i_ref_rank,
    input  logic [RANK_W-1:0]      i_lru_rank,
    output lce_pkg::t_slot_stat    o_stat,
    output logic [TIME_BITS-1:0]   o_stamp,
    output logic [RANK_W-1:0]      o_rank
);
    import lce_pkg::*;

    logic                 r_valid, n_valid;
    logic [RANK_W-1:0]    r_rank, n_rank;
    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_BITS-1:0] r_stamp;
    logic                 w_load_key;
    logic                 w_load_stamp;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cmd.touch) begin
            if (i_hit) begin
                n_rank = '0;
            end else if (r_valid && (r_rank < i_ref_rank)) begin
                n_rank = r_rank + RANK_W'(1);
            end
        end else if (i_cmd.drop) begin
            if (i_hit) begin
                n_valid = 1'b0;
                n_rank  = '0;
            end else if (r_valid && (r_rank > i_ref_rank)) begin
                n_rank = r_rank - RANK_W'(1);
            end
        end else if (i_cmd.fill) begin
            if (i_new) begin
                n_valid = 1'b1;
                n_rank  = '0;
            end else if (i_victim) begin
                n_valid = 1'b0;
                n_rank  = '0;
            end else if (r_valid) begin
                n_rank = r_rank + RANK_W'(1);
            end
        end
    end

    assign w_load_key   = i_cmd.fill && i_new;
    assign w_load_stamp = w_load_key || (i_cmd.restamp && i_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_key) begin
            r_key <= i_key;
        end
        if (w_load_stamp) begin
            r_stamp <= i_time;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.match = r_valid && (r_key == i_key);
    assign o_stat.lru   = r_valid && (r_rank == i_lru_rank);
    assign o_stamp      = r_stamp;
    assign o_rank       = r_rank;

endmodule

// ===== rtl/lru_cache_with_expiry.sv =====
// ----------------------------------------------------------------------------
// LRU cache with expiry - top level
// Fully associative key set in least-recently-used order with time stamps.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (opcode, key) is taken at a rising edge with
//   start high and busy low. busy is never raised, so one item can go in on
//   every clock. Opcodes: lookup, insert or refresh, one time tick.
//   Result channel: o_valid strobes for exactly one cycle with hit, expired,
//   evicted and occupancy; the result is taken at the edge ending that cycle
//   and the receiver cannot hold it off.
//   Flow: an item that is taken sits in the input register, is looked up
//   against all slots in parallel and then updates the slots and the result
//   register together, from which its result strobes on o_valid.
//   Throughput: one item per cycle, set by the parallel key compare and
//   rank update across all slots between the two registers.
//   Configuration: i_cfg_we writes capacity (index 0) or expiry_ticks
//   (index 1); write only while no item is in flight.
//   Reset (synchronous, active low): all slots invalid, ranks zero, time
//   zero, occupancy zero, capacity 16, expiry 60 ticks; no clearing pass.
// ----------------------------------------------------------------------------
`include "lru_cache_with_expiry_assert.svh"

module lru_cache_with_expiry #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 32,
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [lce_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [lce_pkg::KEY_IN_W-1:0]  i_key,
    // result channel
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_expired,
    output logic                          o_evicted,
    output logic [lce_pkg::OCC_W-1:0]     o_occupancy,
    // configuration port
    input  logic                          i_cfg_we,
    input  logic [lce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lce_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // configuration registers
    logic [CAP_W-1:0]     r_capacity;
    logic [EXPIRY_W-1:0]  r_expiry;

    // input register
    logic                 r_in_vld;
    logic [OPCODE_W-1:0]  r_op;
    logic [KEY_BITS-1:0]  r_key;

    // block state
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [CNT_W-1:0]     r_count, n_count;

    // result register
    logic                 r_out_vld;
    logic                 r_hit, n_hit;
    logic                 r_expired, n_expired;
    logic                 r_evicted, n_evicted;
    logic [OCC_W-1:0]     r_occ;

    // slot interface
    t_slot_cmd            w_cmd;
    t_slot_stat           w_stat [ENTRIES];
    logic [TIME_BITS-1:0] w_stamp [ENTRIES];
    logic [RANK_W-1:0]    w_rank [ENTRIES];
    logic [ENTRIES-1:0]   w_valid;
    logic [ENTRIES-1:0]   w_match;
    logic [ENTRIES-1:0]   w_lru;
    logic [ENTRIES-1:0]   w_victim;
    logic [ENTRIES-1:0]   w_free;
    logic [ENTRIES-1:0]   w_free_neg;
    logic [ENTRIES-1:0]   w_new;
    logic                 w_any_match;
    logic [TIME_BITS-1:0] w_hit_stamp;
    logic [RANK_W-1:0]    w_hit_rank;
    logic [RANK_W-1:0]    w_lru_rank;
    logic [TIME_BITS-1:0] w_age;
    logic                 w_is_old;
    logic [CMP_W-1:0]     w_cap_ext;
    logic [CMP_W-1:0]     w_eff_cap;
    logic                 w_full;
    logic                 w_evict;

    // never stalls: each item is finished in the cycle after it is taken
    assign busy = 1'b0;

    // -------------------------------------------------------------------------
    // Configuration
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_expiry   <= EXPIRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_EXPIRY:   r_expiry   <= i_cfg_data[EXPIRY_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // Input register
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= i_opcode;
            r_key <= KEY_BITS'(i_key);
        end
    end

    // -------------------------------------------------------------------------
    // Slots
    // -------------------------------------------------------------------------
    // least recent valid entry holds rank occupancy - 1
    assign w_lru_rank = RANK_W'(r_count - CNT_W'(1));

    for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
        lce_slot #(
            .KEY_BITS  (KEY_BITS),
            .TIME_BITS (TIME_BITS),
            .RANK_W    (RANK_W)
        ) u_slot (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_hit      (w_match[g]),
            .i_victim   (w_victim[g]),
            .i_new      (w_new[g]),
            .i_key      (r_key),
            .i_time     (r_time),
            .i_ref_rank (w_hit_rank),
            .i_lru_rank (w_lru_rank),
            .o_stat     (w_stat[g]),
            .o_stamp    (w_stamp[g]),
            .o_rank     (w_rank[g])
        );
        assign w_valid[g] = w_stat[g].valid;
        assign w_match[g] = w_stat[g].match;
        assign w_lru[g]   = w_stat[g].lru;
    end

    // pick stamp and rank of the matching slot; at most one slot matches
    always_comb begin
        w_hit_stamp = '0;
        w_hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_stamp = w_hit_stamp | (w_stamp[i] & {TIME_BITS{w_match[i]}});
            w_hit_rank  = w_hit_rank  | (w_rank[i]  & {RANK_W{w_match[i]}});
        end
    end

    assign w_any_match = |w_match;
    assign w_age       = r_time - w_hit_stamp;
    assign w_is_old    = w_age >= TIME_BITS'(r_expiry);

    // capacity zero acts as one, above the slot count as the slot count
    assign w_cap_ext = CMP_W'(r_capacity);
    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end
    assign w_full = CMP_W'(r_count) >= w_eff_cap;

    // insert of a new key: evict the least recent when full, then take the
    // lowest free slot (the victim counts as free)
    assign w_evict    = r_in_vld && (r_op == OP_PUT) && !w_any_match && w_full;
    assign w_victim   = w_lru & {ENTRIES{w_evict}};
    assign w_free     = ~w_valid | w_victim;
    assign w_free_neg = ~w_free + ENTRIES'(1);
    assign w_new      = w_free & w_free_neg;

    // -------------------------------------------------------------------------
    // Per-item control
    // -------------------------------------------------------------------------
    always_comb begin
        w_cmd     = '0;
        n_time    = r_time;
        n_count   = r_count;
        n_hit     = 1'b0;
        n_expired = 1'b0;
        n_evicted = 1'b0;
        if (r_in_vld) begin
            case (r_op)
                OP_GET: begin
                    if (w_any_match) begin
                        if (w_is_old) begin
                            w_cmd.drop = 1'b1;
                            n_count    = r_count - CNT_W'(1);
                            n_expired  = 1'b1;
                        end else begin
                            w_cmd.touch = 1'b1;
                            n_hit       = 1'b1;
                        end
                    end
                end
                OP_PUT: begin
                    if (w_any_match) begin
                        w_cmd.touch   = 1'b1;
                        w_cmd.restamp = 1'b1;
                    end else begin
                        w_cmd.fill = 1'b1;
                        n_evicted  = w_evict;
                        if (!w_evict) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                OP_TICK: begin
                    n_time = r_time + TIME_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_time    <= n_time;
            r_count   <= n_count;
            r_out_vld <= r_in_vld;
        end
    end

    // hold result fields for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_hit     <= n_hit;
            r_expired <= n_expired;
            r_evicted <= n_evicted;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hit       = r_hit;
    assign o_expired   = r_expired;
    assign o_evicted   = r_evicted;
    assign o_occupancy = r_occ;

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    `LCE_ASSERT(a_result_follows, i_clk, i_rst_n, r_in_vld |=> o_valid, "item without result")
    `LCE_ASSERT(a_key_unique, i_clk, i_rst_n, $onehot0(w_match), "key held in two slots")
    `LCE_ASSERT(a_count_tracks, i_clk, i_rst_n, r_count == CNT_W'($countones(w_valid)), "occupancy off valid slots")
    `LCE_ASSERT(a_lru_single, i_clk, i_rst_n, (r_count != '0) |-> $onehot(w_lru), "no single least recent slot")
    `LCE_ASSERT(a_flags_exclusive, i_clk, i_rst_n, o_valid |-> $onehot0({o_hit, o_expired, o_evicted}), "result flags overlap")

endmodule
